[rtl/core/rcpwm_pkg.sv]
// Shared types, codes, reset values and the width clamp for the RC-PWM pulse generator.
package rcpwm_pkg;

  // Request kinds
  typedef enum logic [2:0] {
    KIND_WRITE     = 3'd0,
    KIND_READ      = 3'd1,
    KIND_RESET_ALL = 3'd2,
    KIND_START     = 3'd3,
    KIND_TICK      = 3'd4
  } kind_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ENABLE        = 3'd0,
    REG_CHANNEL_COUNT = 3'd1,
    REG_PULSE_MIN     = 3'd2,
    REG_PULSE_MAX     = 3'd3,
    REG_PULSE_NEUTRAL = 3'd4
  } reg_idx_t;

  localparam int KIND_W  = 3;
  localparam int CHAN_W  = 3;
  localparam int WIDTH_W = 16;
  localparam int COUNT_W = 4;
  localparam int PINS_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT = 4'd1;
  localparam logic [WIDTH_W-1:0] RST_PULSE_MIN     = 16'd1000;
  localparam logic [WIDTH_W-1:0] RST_PULSE_MAX     = 16'd2000;
  localparam logic [WIDTH_W-1:0] RST_PULSE_NEUTRAL = 16'd1500;
  localparam logic [WIDTH_W-1:0] ELAPSED_SAT       = 16'hFFFF;

  // Control from the sequencer to the width store
  typedef struct packed {
    logic write;
    logic clear;
  } store_ctl_t;

  // Lower bound wins first, then upper bound
  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w,
                                                     input logic [WIDTH_W-1:0] lo,
                                                     input logic [WIDTH_W-1:0] hi);
    logic [WIDTH_W-1:0] r;
    if (w < lo) r = lo;
    else if (w > hi) r = hi;
    else r = w;
    return r;
  endfunction

endpackage

[rtl/core/rcpwm_req_if.sv]
// Request channel: command kind, channel index and requested pulse width.
interface rcpwm_req_if import rcpwm_pkg::*;;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [CHAN_W-1:0]   channel;
  logic [WIDTH_W-1:0]  pulse_width;

  modport source (output valid, output kind, output channel, output pulse_width, input ready);
  modport sink   (input valid, input kind, input channel, input pulse_width, output ready);
endinterface

[rtl/core/rcpwm_res_if.sv]
// Result channel: status, read data, pin levels and frame busy flag.
interface rcpwm_res_if import rcpwm_pkg::*;;
  logic                valid;
  logic                ready;
  logic                ok;
  logic [WIDTH_W-1:0]  read_width;
  logic [PINS_W-1:0]   pin_levels;
  logic                frame_busy;

  modport source (output valid, output ok, output read_width, output pin_levels,
                  output frame_busy, input ready);
  modport sink   (input valid, input ok, input read_width, input pin_levels,
                  input frame_busy, output ready);
endinterface

[rtl/core/rcpwm_cfg_if.sv]
// Configuration write channel: register index and write data.
interface rcpwm_cfg_if import rcpwm_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/rcpwm_width_store.sv]
// Per-channel pulse width registers with one write port, bulk load and one read port.
module rcpwm_width_store import rcpwm_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  store_ctl_t         ctl,
  input  logic [IDX_W-1:0]   wr_idx,
  input  logic [WIDTH_W-1:0] wr_data,
  input  logic [WIDTH_W-1:0] clear_data,
  input  logic [IDX_W-1:0]   rd_idx,
  output logic [WIDTH_W-1:0] rd_data
);

  logic [WIDTH_W-1:0] widths [DEPTH];

  // Bulk load overrides a single write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) widths[i] <= '0;
    end else if (ctl.clear) begin
      for (int i = 0; i < DEPTH; i++) widths[i] <= clear_data;
    end else if (ctl.write) begin
      widths[wr_idx] <= wr_data;
    end
  end

  // Indexes past the depth read as zero
  always_comb begin
    if (32'(rd_idx) < DEPTH) rd_data = widths[rd_idx];
    else rd_data = '0;
  end

endmodule

[rtl/core/rc_pwm_sequential_pulse_gen.sv]
// Top level of the multi-channel RC servo PWM pulse generator.
//
//   channel | dir | fields                                         | accepted when
//   in_ch   | in  | kind, channel, pulse_width                     | valid && ready
//   out_ch  | out | ok, read_width, pin_levels, frame_busy         | valid && ready
//   cfg     | in  | index, data (enable, count, min, max, neutral) | valid && ready
//
// One request per cycle sustained while the result side does not stall; each
// request passes a request register and then a result register, where its
// result is offered and held until it is taken.
// All state update for a request is one compare/increment in the result stage.
// Reset (rst, synchronous) zeroes the width store, drops all pins, ends any frame
// and loads register defaults. A stalled result holds the result register and
// the request register in turn; the config port is always ready.
module rc_pwm_sequential_pulse_gen import rcpwm_pkg::*; #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  rcpwm_req_if.sink   in_ch,
  rcpwm_res_if.source out_ch,
  rcpwm_cfg_if.sink   cfg
);

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = ($clog2(MAX_CHANNELS + 1) > COUNT_W) ?
                         $clog2(MAX_CHANNELS + 1) : COUNT_W;

  // Configuration registers
  logic               enable;
  logic [COUNT_W-1:0] channel_count;
  logic [WIDTH_W-1:0] pulse_min;
  logic [WIDTH_W-1:0] pulse_max;
  logic [WIDTH_W-1:0] pulse_neutral;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      channel_count <= RST_CHANNEL_COUNT;
      pulse_min     <= RST_PULSE_MIN;
      pulse_max     <= RST_PULSE_MAX;
      pulse_neutral <= RST_PULSE_NEUTRAL;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_ENABLE:        enable        <= cfg.data[0];
        REG_CHANNEL_COUNT: channel_count <= cfg.data[COUNT_W-1:0];
        REG_PULSE_MIN:     pulse_min     <= cfg.data;
        REG_PULSE_MAX:     pulse_max     <= cfg.data;
        REG_PULSE_NEUTRAL: pulse_neutral <= cfg.data;
        default: ;
      endcase
    end
  end

  // Request register and result register handshake
  logic               req_valid;
  logic [KIND_W-1:0]  req_kind;
  logic [CHAN_W-1:0]  req_channel;
  logic [WIDTH_W-1:0] req_width;

  logic               res_valid;
  logic               res_ok;
  logic [WIDTH_W-1:0] res_read_width;
  logic [PINS_W-1:0]  res_pins;
  logic               res_busy;

  logic advance;
  logic fire;

  assign advance     = !res_valid || out_ch.ready;
  assign fire        = req_valid && advance;
  assign in_ch.ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ch.ready) begin
      req_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      req_kind    <= in_ch.kind;
      req_channel <= in_ch.channel;
      req_width   <= in_ch.pulse_width;
    end
  end

  // Frame state
  logic               frame_active;
  logic [IDX_W-1:0]   current_channel;
  logic [WIDTH_W-1:0] elapsed_us;
  logic [WIDTH_W-1:0] latched_width;
  logic [PINS_W-1:0]  pin_state;

  logic               frame_active_next;
  logic [IDX_W-1:0]   current_channel_next;
  logic [WIDTH_W-1:0] elapsed_us_next;
  logic [WIDTH_W-1:0] latched_width_next;
  logic [PINS_W-1:0]  pin_state_next;
  logic               ok_next;
  logic [WIDTH_W-1:0] read_width_next;

  // Width store hookup
  store_ctl_t         st_ctl;
  logic [IDX_W-1:0]   st_rd_idx;
  logic [WIDTH_W-1:0] st_rd_data;
  logic [IDX_W-1:0]   st_wr_idx;
  logic [WIDTH_W-1:0] st_wr_data;
  logic [WIDTH_W-1:0] st_clear_data;

  rcpwm_width_store #(
    .DEPTH (MAX_CHANNELS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctl        (st_ctl),
    .wr_idx     (st_wr_idx),
    .wr_data    (st_wr_data),
    .clear_data (st_clear_data),
    .rd_idx     (st_rd_idx),
    .rd_data    (st_rd_data)
  );

  // Helper values
  logic [CNT_W-1:0]   act_count;
  logic [CNT_W-1:0]   chan_ext;
  logic [CNT_W-1:0]   next_chan;
  logic               access_ok;
  logic [WIDTH_W-1:0] elapsed_inc;
  logic [PINS_W-1:0]  cur_mask;
  logic [PINS_W-1:0]  next_mask;

  always_comb begin
    if (CNT_W'(channel_count) < CNT_W'(MAX_CHANNELS)) act_count = CNT_W'(channel_count);
    else act_count = CNT_W'(MAX_CHANNELS);
    chan_ext    = CNT_W'(req_channel);
    next_chan   = CNT_W'(current_channel) + CNT_W'(1);
    access_ok   = enable && (chan_ext < act_count);
    elapsed_inc = (elapsed_us == ELAPSED_SAT) ? elapsed_us : elapsed_us + WIDTH_W'(1);
    // Pins beyond the visible eight have no output bit
    for (int i = 0; i < PINS_W; i++) begin
      cur_mask[i]  = (CNT_W'(current_channel) == CNT_W'(i));
      next_mask[i] = (next_chan == CNT_W'(i));
    end
  end

  assign st_wr_idx     = chan_ext[IDX_W-1:0];
  assign st_wr_data    = clamp_width(req_width, pulse_min, pulse_max);
  assign st_clear_data = enable ? pulse_neutral : '0;

  // Single read port: the read address, channel zero on start, else the next channel
  always_comb begin
    if (kind_t'(req_kind) == KIND_READ) st_rd_idx = chan_ext[IDX_W-1:0];
    else if (kind_t'(req_kind) == KIND_START) st_rd_idx = '0;
    else st_rd_idx = next_chan[IDX_W-1:0];
  end

  // Request decode and state update
  always_comb begin
    frame_active_next    = frame_active;
    current_channel_next = current_channel;
    elapsed_us_next      = elapsed_us;
    latched_width_next   = latched_width;
    pin_state_next       = pin_state;
    ok_next              = 1'b0;
    read_width_next      = '0;
    st_ctl               = '0;

    unique case (kind_t'(req_kind))
      KIND_WRITE: begin
        if (access_ok) begin
          st_ctl.write = fire;
          ok_next      = 1'b1;
        end
      end
      KIND_READ: begin
        if (access_ok) begin
          read_width_next = st_rd_data;
          ok_next         = 1'b1;
        end
      end
      KIND_RESET_ALL: begin
        st_ctl.clear         = fire;
        pin_state_next       = '0;
        frame_active_next    = 1'b0;
        current_channel_next = '0;
        elapsed_us_next      = '0;
        latched_width_next   = '0;
      end
      KIND_START: begin
        if (enable && !frame_active && act_count != '0) begin
          frame_active_next    = 1'b1;
          current_channel_next = '0;
          elapsed_us_next      = '0;
          latched_width_next   = st_rd_data;
          pin_state_next       = pin_state | PINS_W'(1);
          ok_next              = 1'b1;
        end
      end
      KIND_TICK: begin
        if (frame_active && enable) begin
          if (elapsed_inc < latched_width) begin
            elapsed_us_next = elapsed_inc;
          end else if (next_chan < act_count) begin
            current_channel_next = next_chan[IDX_W-1:0];
            latched_width_next   = st_rd_data;
            elapsed_us_next      = '0;
            pin_state_next       = (pin_state & ~cur_mask) | next_mask;
          end else begin
            pin_state_next       = pin_state & ~cur_mask;
            frame_active_next    = 1'b0;
            current_channel_next = '0;
            elapsed_us_next      = '0;
            latched_width_next   = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active    <= 1'b0;
      current_channel <= '0;
      elapsed_us      <= '0;
      latched_width   <= '0;
      pin_state       <= '0;
    end else if (fire) begin
      frame_active    <= frame_active_next;
      current_channel <= current_channel_next;
      elapsed_us      <= elapsed_us_next;
      latched_width   <= latched_width_next;
      pin_state       <= pin_state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_ok         <= ok_next;
      res_read_width <= read_width_next;
      res_pins       <= pin_state_next;
      res_busy       <= frame_active_next;
    end
  end

  assign out_ch.valid      = res_valid;
  assign out_ch.ok         = res_ok;
  assign out_ch.read_width = res_read_width;
  assign out_ch.pin_levels = res_pins;
  assign out_ch.frame_busy = res_busy;

endmodule
